>>> rtl/core/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg
// Shared constants, types and the set-membership function of the token
// affix splitter.
// ----------------------------------------------------------------------------
package tas_pkg;

    localparam int MAX_TOKEN_UNITS = 64;
    localparam int SET_ENTRIES     = 8;

    localparam int UNIT_W       = 16;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int SET_CNT_W    = 4;
    localparam int UNITS_PER_WD = CFG_W / UNIT_W;
    localparam int ADDR_W       = (MAX_TOKEN_UNITS > 1) ? $clog2(MAX_TOKEN_UNITS) : 1;
    localparam int CNT_W        = $clog2(MAX_TOKEN_UNITS + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PFX_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PFX_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PFX_CNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SFX_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SFX_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SFX_CNT = 3'd5;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PREFIX = 2'd0;
    localparam t_kind KIND_BODY   = 2'd1;
    localparam t_kind KIND_SUFFIX = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic take_in;      // input side open
        logic ptr_clr;
        logic ptr_inc;
        logic ptr_dec;
        logic ptr_load_len;
        logic addr_back;    // read at ptr-1 (backward scan)
        logic latch_b;
        logic latch_e;
        logic out_load;
        logic token_clr;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic pfx_hit;
        logic sfx_hit;
        logic ptr_lt_len;
        logic ptr_gt_b;
        logic ptr_is_last;
        logic out_free;
    } t_sts;

    function automatic logic set_match(input logic [CFG_W-1:0]     lo,
                                       input logic [CFG_W-1:0]     hi,
                                       input logic [SET_CNT_W-1:0] cnt,
                                       input logic [UNIT_W-1:0]    u);
        logic                 hit;
        logic [SET_CNT_W-1:0] n;
        logic [UNIT_W-1:0]    ent;
        hit = 1'b0;
        n   = (cnt > SET_CNT_W'(SET_ENTRIES)) ? SET_CNT_W'(SET_ENTRIES) : cnt;
        for (int i = 0; i < SET_ENTRIES; i++) begin
            if (i < UNITS_PER_WD) begin
                ent = lo[(i % UNITS_PER_WD)*UNIT_W +: UNIT_W];
            end else begin
                ent = hi[(i % UNITS_PER_WD)*UNIT_W +: UNIT_W];
            end
            if ((SET_CNT_W'(i) < n) && (ent == u)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/core/tas_in_if.sv
// ----------------------------------------------------------------------------
// tas_in_if
// Input channel: one code unit of a token per request.
// ----------------------------------------------------------------------------
interface tas_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        token_end;

    modport source (output valid, output code_unit, output token_end, input ready);
    modport sink   (input valid, input code_unit, input token_end, output ready);
endinterface

>>> rtl/core/tas_out_if.sv
// ----------------------------------------------------------------------------
// tas_out_if
// Output channel: one code unit of an emitted piece per request.
// ----------------------------------------------------------------------------
interface tas_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_unit;
    logic [1:0]  piece_kind;
    logic        piece_end;
    logic        was_cut;
    logic        truncated;
    logic        run_end;

    modport source (output valid, output out_unit, output piece_kind, output piece_end,
                    output was_cut, output truncated, output run_end, input ready);
    modport sink   (input valid, input out_unit, input piece_kind, input piece_end,
                    input was_cut, input truncated, input run_end, output ready);
endinterface

>>> rtl/core/tas_ctrl.sv
// ----------------------------------------------------------------------------
// tas_ctrl
// Sequencer: fill, forward prefix scan, backward suffix scan, emission.
// ----------------------------------------------------------------------------
module tas_ctrl
    import tas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_FILL    = 7'b0000001,
        S_PFX_RD  = 7'b0000010,
        S_PFX_CHK = 7'b0000100,
        S_SFX_RD  = 7'b0001000,
        S_SFX_CHK = 7'b0010000,
        S_EMIT_RD = 7'b0100000,
        S_EMIT_LD = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_FILL: begin
                o_cmd.take_in = 1'b1;
                if (i_sts.in_fire && i_sts.in_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_PFX_RD;
                end
            end
            S_PFX_RD: begin
                n_state = S_PFX_CHK;
            end
            S_PFX_CHK: begin
                if (i_sts.ptr_lt_len && i_sts.pfx_hit) begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_PFX_RD;
                end else begin
                    o_cmd.latch_b      = 1'b1;
                    o_cmd.ptr_load_len = 1'b1;
                    n_state            = S_SFX_RD;
                end
            end
            S_SFX_RD: begin
                o_cmd.addr_back = 1'b1;
                n_state         = S_SFX_CHK;
            end
            S_SFX_CHK: begin
                o_cmd.addr_back = 1'b1;
                if (i_sts.ptr_gt_b && i_sts.sfx_hit) begin
                    o_cmd.ptr_dec = 1'b1;
                    n_state       = S_SFX_RD;
                end else begin
                    o_cmd.latch_e = 1'b1;
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.ptr_is_last) begin
                        o_cmd.token_clr = 1'b1;
                        n_state         = S_FILL;
                    end else begin
                        o_cmd.ptr_inc = 1'b1;
                        n_state       = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

endmodule

>>> rtl/core/tas_dpath.sv
// ----------------------------------------------------------------------------
// tas_dpath
// Unit buffer, set registers, scan pointer and output register.
// ----------------------------------------------------------------------------
module tas_dpath
    import tas_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    tas_in_if.sink               i_in,
    tas_out_if.source            o_out
);

    logic [CFG_W-1:0]     r_pfx_lo, r_pfx_hi, r_sfx_lo, r_sfx_hi;
    logic [SET_CNT_W-1:0] r_pfx_cnt, r_sfx_cnt;

    logic [UNIT_W-1:0] r_mem [MAX_TOKEN_UNITS];
    logic [UNIT_W-1:0] r_rdata;
    logic [ADDR_W-1:0] rd_addr;

    logic [CNT_W-1:0] r_fill, r_ptr, r_b, r_e;
    logic [CNT_W-1:0] ptr_back;
    logic             r_ovf;
    logic             in_fire;
    logic             has_room;

    logic              r_out_valid;
    logic [UNIT_W-1:0] r_out_unit;
    t_kind             r_out_kind;
    logic              r_out_pend, r_out_cut, r_out_trunc, r_out_rend;
    t_kind             n_kind;
    logic              n_pend;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx_lo  <= '0;
            r_pfx_hi  <= '0;
            r_pfx_cnt <= '0;
            r_sfx_lo  <= '0;
            r_sfx_hi  <= '0;
            r_sfx_cnt <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PFX_LO:  r_pfx_lo  <= i_cfg_data;
                CFG_PFX_HI:  r_pfx_hi  <= i_cfg_data;
                CFG_PFX_CNT: r_pfx_cnt <= i_cfg_data[SET_CNT_W-1:0];
                CFG_SFX_LO:  r_sfx_lo  <= i_cfg_data;
                CFG_SFX_HI:  r_sfx_hi  <= i_cfg_data;
                CFG_SFX_CNT: r_sfx_cnt <= i_cfg_data[SET_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input side
    assign i_in.ready = i_cmd.take_in;
    assign in_fire    = i_in.valid && i_cmd.take_in;
    assign has_room   = (r_fill < CNT_W'(MAX_TOKEN_UNITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.token_clr) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end else if (in_fire) begin
            if (has_room) begin
                r_fill <= r_fill + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Unit buffer: one write port, one registered read port
    assign ptr_back = r_ptr - CNT_W'(1);
    assign rd_addr  = i_cmd.addr_back ? ptr_back[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (in_fire && has_room) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_in.code_unit;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Scan pointer and split points
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_b   <= '0;
            r_e   <= '0;
        end else begin
            if (i_cmd.latch_b) begin
                r_b <= r_ptr;
            end
            if (i_cmd.latch_e) begin
                r_e <= r_ptr;
            end
            priority if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_load_len) begin
                r_ptr <= r_fill;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end else if (i_cmd.ptr_dec) begin
                r_ptr <= ptr_back;
            end else begin
                r_ptr <= r_ptr;
            end
        end
    end

    // Piece classification of the unit at r_ptr
    always_comb begin
        priority if (r_ptr < r_b) begin
            n_kind = KIND_PREFIX;
            n_pend = 1'b1;
        end else if (r_ptr < r_e) begin
            n_kind = KIND_BODY;
            n_pend = (r_ptr + CNT_W'(1) == r_e);
        end else begin
            n_kind = KIND_SUFFIX;
            n_pend = 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_unit  <= r_rdata;
            r_out_kind  <= n_kind;
            r_out_pend  <= n_pend;
            r_out_cut   <= (r_b != '0) || (r_e != r_fill);
            r_out_trunc <= r_ovf;
            r_out_rend  <= (r_ptr + CNT_W'(1) == r_fill);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_unit   = r_out_unit;
    assign o_out.piece_kind = r_out_kind;
    assign o_out.piece_end  = r_out_pend;
    assign o_out.was_cut    = r_out_cut;
    assign o_out.truncated  = r_out_trunc;
    assign o_out.run_end    = r_out_rend;

    // Status
    assign o_sts.in_fire     = in_fire;
    assign o_sts.in_last     = i_in.token_end;
    assign o_sts.pfx_hit     = set_match(r_pfx_lo, r_pfx_hi, r_pfx_cnt, r_rdata);
    assign o_sts.sfx_hit     = set_match(r_sfx_lo, r_sfx_hi, r_sfx_cnt, r_rdata);
    assign o_sts.ptr_lt_len  = (r_ptr < r_fill);
    assign o_sts.ptr_gt_b    = (r_ptr > r_b);
    assign o_sts.ptr_is_last = (r_ptr + CNT_W'(1) == r_fill);
    assign o_sts.out_free    = !r_out_valid || o_out.ready;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_TOKEN_UNITS))
        else $error("fill count above buffer depth");

    a_token_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.token_clr |=> (r_fill == '0) && !r_ovf)
        else $error("token state not cleared");

    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (r_b <= r_e) && (r_e <= r_fill) && (r_ptr < r_fill))
        else $error("emission outside split bounds");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid || o_out.ready)
        else $error("result loaded over a pending request");

endmodule

>>> rtl/core/token_affix_splitter.sv
// ----------------------------------------------------------------------------
// token_affix_splitter
// Buffers the code units of a token and emits it split into single-unit
// prefix pieces, at most one body piece and single-unit suffix pieces.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake        Payload
//  i_in      in    valid / ready    code_unit[15:0], token_end
//  o_out     out   valid / ready    out_unit[15:0], piece_kind[1:0], piece_end,
//                                   was_cut, truncated, run_end
//  i_cfg_*   in    write enable     i_cfg_idx[2:0], i_cfg_data[63:0]
//
//  Sequence: while filling, i_in stays open until the unit marked token_end.
//  At the token end the controller scans the buffer through its single read
//  port, forward over the prefix run and backward over the suffix run, each
//  unit read and then checked, then reads and loads each unit for emission.
//  Reset: synchronous, active low; clears control state and the set registers.
//  Stalls: o_out holds its request while ready is low; emission pauses and
//  i_in stays closed until the last unit of the token has been loaded.
// ----------------------------------------------------------------------------
module token_affix_splitter
    import tas_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tas_in_if.sink               i_in,
    tas_out_if.source            o_out
);

    // Command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // Sequencer: fill, scan for prefix run, scan back for suffix run, emit
    tas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: buffer memory, set match, pointers, output register
    tas_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

>>> sim/token_affix_splitter_tb.sv
// ----------------------------------------------------------------------------
// token_affix_splitter_tb
// Self-checking bench for the token affix splitter. A queue-fed driver sends
// code units with random gaps, a monitor predicts the emitted pieces of every
// finished token and checks each output request against the oldest
// expectation. The prefix and suffix sets are reprogrammed between phases.
// ----------------------------------------------------------------------------
module token_affix_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tas_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_SHOWN     = 40;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_val;
        t_kind             kind;
        logic              piece_end;
        logic              was_cut;
        logic              truncated;
        logic              run_end;
    } t_piece_unit;

    typedef struct {
        logic [UNIT_W-1:0] code_unit;
        logic              token_end;
    } t_code_req;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    tas_in_if  in_if ();
    tas_out_if out_if ();

    token_affix_splitter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Shadow copy of the set registers
    logic [CFG_W-1:0]     pfx_lo = '0;
    logic [CFG_W-1:0]     pfx_hi = '0;
    logic [SET_CNT_W-1:0] pfx_n  = '0;
    logic [CFG_W-1:0]     sfx_lo = '0;
    logic [CFG_W-1:0]     sfx_hi = '0;
    logic [SET_CNT_W-1:0] sfx_n  = '0;

    // Shadow token buffer
    logic [UNIT_W-1:0] tok_units [MAX_TOKEN_UNITS];
    int                tok_len  = 0;
    logic              tok_over = 1'b0;

    t_code_req   unit_queue[$];
    t_piece_unit expected_pieces[$];

    int   units_pushed   = 0;
    int   units_accepted = 0;
    int   result_cnt     = 0;
    int   token_cnt      = 0;
    int   cut_cnt        = 0;
    int   trunc_cnt      = 0;
    int   setting_cnt    = 0;
    int   err_cnt        = 0;
    int   cycle_cnt      = 0;
    int   in_wait        = 0;
    int   out_wait       = 0;
    bit   in_calm        = 1'b0;
    bit   out_calm       = 1'b0;
    bit   in_fire_q      = 1'b0;
    bit   out_fire_q     = 1'b0;
    t_code_req next_req;

    // ------------------------------------------------------------------------
    // Set lookup and piece prediction
    // ------------------------------------------------------------------------
    function automatic logic [UNIT_W-1:0] set_entry(logic [CFG_W-1:0] lo,
                                                    logic [CFG_W-1:0] hi, int idx);
        logic [CFG_W-1:0] word;
        word = (idx < 4) ? lo : hi;
        return word[(idx % 4)*UNIT_W +: UNIT_W];
    endfunction

    // Counts above the entry total saturate; a zero count matches nothing
    function automatic bit unit_in_set(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                                       logic [SET_CNT_W-1:0] cnt, logic [UNIT_W-1:0] u);
        int lim;
        lim = (cnt > SET_ENTRIES) ? SET_ENTRIES : int'(cnt);
        for (int i = 0; i < lim; i++) begin
            if (set_entry(lo, hi, i) == u) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Buffer one accepted unit; on the token end, queue every emitted piece unit
    function automatic void predict_pieces(logic [UNIT_W-1:0] u, logic last);
        int          head;
        int          tail;
        logic        cut;
        t_piece_unit p;
        if (tok_len < MAX_TOKEN_UNITS) begin
            tok_units[tok_len] = u;
            tok_len++;
        end else begin
            tok_over = 1'b1;
        end
        if (!last) return;
        head = 0;
        while (head < tok_len && unit_in_set(pfx_lo, pfx_hi, pfx_n, tok_units[head]))
            head++;
        // Backward scan never crosses into the prefix run
        tail = tok_len;
        while (tail > head && unit_in_set(sfx_lo, sfx_hi, sfx_n, tok_units[tail-1]))
            tail--;
        cut = (head != 0) || (tail != tok_len);
        for (int i = 0; i < tok_len; i++) begin
            p.unit_val  = tok_units[i];
            p.kind      = (i < head) ? KIND_PREFIX : (i < tail) ? KIND_BODY : KIND_SUFFIX;
            p.piece_end = (p.kind != KIND_BODY) || (i + 1 == tail);
            p.was_cut   = cut;
            p.truncated = tok_over;
            p.run_end   = (i == tok_len - 1);
            expected_pieces.push_back(p);
        end
        tok_len  = 0;
        tok_over = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: launch the next queued unit at the falling edge once the
    // current request has been taken, after the gap drawn for it.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (in_fire_q || !in_if.valid) begin
            if (in_wait > 0) begin
                in_wait--;
                in_if.valid <= 1'b0;
            end else if (unit_queue.size() > 0) begin
                next_req = unit_queue.pop_front();
                in_if.code_unit <= next_req.code_unit;
                in_if.token_end <= next_req.token_end;
                in_if.valid     <= 1'b1;
                in_wait = in_calm ? 0 : $urandom_range(0, 9);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Sink: stall a random number of cycles after each taken result
    always @(negedge i_clk) begin
        if (out_fire_q) out_wait = out_calm ? 0 : $urandom_range(0, 9);
        if (out_wait > 0) begin
            out_wait--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, predict on each
    // accepted unit and check each accepted result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_piece_unit got;
        t_piece_unit want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, cycle_cnt, expected_pieces.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            in_fire_q  <= in_if.valid && in_if.ready;
            out_fire_q <= out_if.valid && out_if.ready;
            if (i_rst_n && in_if.valid && in_if.ready) begin
                predict_pieces(in_if.code_unit, in_if.token_end);
                units_accepted++;
            end
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.unit_val  = out_if.out_unit;
                got.kind      = out_if.piece_kind;
                got.piece_end = out_if.piece_end;
                got.was_cut   = out_if.was_cut;
                got.truncated = out_if.truncated;
                got.run_end   = out_if.run_end;
                result_cnt++;
                if (got.run_end === 1'b1) begin
                    token_cnt++;
                    if (got.was_cut === 1'b1) cut_cnt++;
                    if (got.truncated === 1'b1) trunc_cnt++;
                end
                if (expected_pieces.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display("%0t: unexpected result, expected none, actual unit=%h kind=%0d",
                                 $time, got.unit_val, got.kind);
                end else begin
                    want = expected_pieces.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= MAX_SHOWN)
                            $display({"%0t: mismatch expected unit=%h kind=%0d end=%b cut=%b ",
                                      "trunc=%b last=%b, actual unit=%h kind=%0d end=%b ",
                                      "cut=%b trunc=%b last=%b"}, $time,
                                     want.unit_val, want.kind, want.piece_end, want.was_cut,
                                     want.truncated, want.run_end,
                                     got.unit_val, got.kind, got.piece_end, got.was_cut,
                                     got.truncated, got.run_end);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_unit(logic [UNIT_W-1:0] u, logic last);
        t_code_req r;
        r.code_unit = u;
        r.token_end = last;
        unit_queue.push_back(r);
        units_pushed++;
    endtask

    // Queue a token spelled as ASCII text, one unit per character
    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_unit(UNIT_W'(s[i]), i == s.len() - 1);
    endtask

    // Hold until every unit is in and every result out, then let the block settle
    task automatic drain();
        do @(negedge i_clk);
        while (units_accepted != units_pushed || expected_pieces.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register at a falling edge; the block is idle, so update the
    // shadow copy right away
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_PFX_LO:  pfx_lo = data;
            CFG_PFX_HI:  pfx_hi = data;
            CFG_PFX_CNT: pfx_n  = data[SET_CNT_W-1:0];
            CFG_SFX_LO:  sfx_lo = data;
            CFG_SFX_HI:  sfx_hi = data;
            CFG_SFX_CNT: sfx_n  = data[SET_CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Program both sets, then poke the unused indexes with junk
    task automatic program_sets(logic [CFG_W-1:0] plo, logic [CFG_W-1:0] phi,
                                logic [CFG_W-1:0] pcnt, logic [CFG_W-1:0] slo,
                                logic [CFG_W-1:0] shi, logic [CFG_W-1:0] scnt);
        write_reg(CFG_PFX_LO, plo);
        write_reg(CFG_PFX_HI, phi);
        write_reg(CFG_PFX_CNT, pcnt);
        write_reg(CFG_SFX_LO, slo);
        write_reg(CFG_SFX_HI, shi);
        write_reg(CFG_SFX_CNT, scnt);
        write_reg(CFG_SPARE_6, {$urandom, $urandom});
        write_reg(CFG_SPARE_7, {$urandom, $urandom});
        setting_cnt++;
    endtask

    // Mostly punctuation so that set hits are common, sometimes any unit
    function automatic logic [CFG_W-1:0] random_set_word();
        logic [CFG_W-1:0] w;
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 4) == 0) w[i*UNIT_W +: UNIT_W] = UNIT_W'($urandom);
            else w[i*UNIT_W +: UNIT_W] = UNIT_W'($urandom_range(16'h21, 16'h2F));
        end
        return w;
    endfunction

    // Draw a unit biased toward the programmed sets (any entry, valid or not)
    function automatic logic [UNIT_W-1:0] pick_unit();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) return set_entry(pfx_lo, pfx_hi, $urandom_range(0, 7));
        if (sel < 65) return set_entry(sfx_lo, sfx_hi, $urandom_range(0, 7));
        if (sel < 92) return UNIT_W'($urandom_range(16'h61, 16'h7A));
        return UNIT_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int               len;
        int               target;
        logic [CFG_W-1:0] pcnt;
        logic [CFG_W-1:0] scnt;
        bit               noisy;

        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.code_unit = '0;
        in_if.token_end = 1'b0;
        out_if.ready    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset sets are empty: zero and all-ones units pass through whole
        in_calm  = 1'b1;
        out_calm = 1'b1;
        push_unit(16'h0000, 1'b1);
        push_unit(16'hFFFF, 1'b1);
        push_text("ab");
        drain();

        // Punctuation sets; the suffix count is above the entry total, and
        // the prefix count write carries junk in the upper bits
        program_sets({16'h0000, 16'h005B, 16'h0022, 16'h0028},
                     {16'h002D, 16'h0027, 16'h007B, 16'hFFFF},
                     64'hFFFF_FFFF_FFFF_FFF8,
                     {16'h0021, 16'h002C, 16'h002E, 16'h0029},
                     {16'hFFFF, 16'h0022, 16'h005D, 16'h003F},
                     64'h0000_0000_0000_000F);
        in_calm  = 1'b0;
        out_calm = 1'b0;
        push_text("(hello).");
        push_text("((["); // prefix units only
        push_text("(.)"); // prefix and suffix with no body
        push_unit(16'hFFFF, 1'b1);
        push_text("x");
        // Overflow: 64 units fill the buffer, the closing unit is dropped
        push_unit(16'h0028, 1'b0);
        for (int i = 0; i < 63; i++) push_unit(16'h0061, 1'b0);
        push_unit(16'h0029, 1'b1);
        drain();

        // All-ones sets, counts saturate
        program_sets('1, '1, 64'hF, '1, '1, 64'hF);
        push_unit(16'hFFFF, 1'b0);
        push_unit(16'h1234, 1'b0);
        push_unit(16'hFFFF, 1'b1);
        push_unit(16'hFFFF, 1'b0);
        push_unit(16'hFFFF, 1'b1);
        push_unit(16'h0000, 1'b1);
        drain();

        // Random phases: fresh sets, mostly well-formed tokens, some noise
        for (int ph = 0; ph < 6; ph++) begin
            pcnt = {$urandom, $urandom};
            scnt = {$urandom, $urandom};
            // Phase three empties both sets, phase five fills them exactly
            if (ph == 3) begin
                pcnt[3:0] = 4'd0;
                scnt[3:0] = 4'd0;
            end else if (ph == 5) begin
                pcnt[3:0] = 4'd8;
                scnt[3:0] = 4'd8;
            end
            program_sets(random_set_word(), random_set_word(), pcnt,
                         random_set_word(), random_set_word(), scnt);
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            target   = units_pushed + 12;
            // One long token in phase two, sized around the buffer limit
            if (ph == 2) begin
                len = $urandom_range(60, 70);
                for (int j = 0; j < len; j++) push_unit(pick_unit(), j == len - 1);
            end
            while (units_pushed < target) begin
                noisy = ($urandom_range(0, 5) == 0);
                len   = $urandom_range(1, 8);
                for (int j = 0; j < len; j++)
                    push_unit(noisy ? UNIT_W'($urandom) : pick_unit(), j == len - 1);
            end
            drain();
        end

        if (expected_pieces.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d expected results never arrived", $time, expected_pieces.size());
        end
        $display("Covered %0d units in %0d tokens over %0d set programmings: %0d results,",
                 units_accepted, token_cnt, setting_cnt, result_cnt);
        $display("%0d tokens cut, %0d truncated, %0d errors", cut_cnt, trunc_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
